// ----- rtl/sida_pkg.sv -----
package sida_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } sida_state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } sida_cmd_t;

    typedef struct packed {
        logic negative;
        logic top_zero;
        logic slot_free;
    } sida_status_t;

endpackage

// ----- rtl/sida_ctrl.sv -----
module sida_ctrl
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sida_status_t status,
    output sida_cmd_t    cmd
);

    localparam int BIT_CW = $clog2(VALUE_BITS);
    localparam int DIG_CW = $clog2(NUM_DIGITS);
    localparam logic [BIT_CW-1:0] BIT_LAST = BIT_CW'(VALUE_BITS - 1);
    localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(NUM_DIGITS - 1);

    sida_state_t        state_reg, state_next;
    logic [BIT_CW-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]  dig_cnt_reg, dig_cnt_next;
    logic               started_reg, started_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            started_reg <= started_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    dig_cnt_next = DIG_LAST;
                    state_next   = status.negative ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                // leading zero suppression
                if (status.top_zero && !started_reg && dig_cnt_reg != '0)
                begin
                    cmd.shift_digit = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                end
                else if (status.slot_free)
                begin
                    cmd.emit_digit  = 1'b1;
                    cmd.shift_digit = 1'b1;
                    cmd.last        = (dig_cnt_reg == '0);
                    started_next    = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sida_dp.sv -----
module sida_dp
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  sida_cmd_t             cmd,
    output sida_status_t          status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            char_code,
    output logic                  is_last
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic                  neg_reg, neg_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add-3 correction on every digit ahead of the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            neg_next = value[VALUE_BITS-1];
            mag_next = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd_next = '0;
        end
        if (cmd.dabble)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
        if (cmd.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
        if (cmd.emit_sign)
        begin
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next      = CHAR_ZERO + {4'd0, top_digit};
            last_next      = cmd.last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.negative  = neg_reg;
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign is_last   = last_reg;

endmodule

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// channel   signals                        direction   content
// in        in_valid, in_ready, value      sink        one signed integer per item
// out       out_valid, out_ready,          source      one ascii character per item,
//           char_code, is_last                         is_last on the final one
//
// an item is accepted, then each of its VALUE_BITS bits is shifted into the bcd register with add-3 correction,
// then each suppressed leading zero is shifted out and each character is emitted
// one number is converted at a time; in_ready is high only while idle
// the output register stalls character emission while out_ready is low
// rst_n clears the controller and the output valid flag, nothing else
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            char_code,
    output logic                  is_last
);

    localparam int NUM_DIGITS = ((VALUE_BITS * 30103) / 100000) + 1;

    sida_cmd_t    cmd;
    sida_status_t status;

    sida_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sida_dp #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .is_last   (is_last)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a conversion is running");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_code == CHAR_MINUS) |-> !is_last)
        else $error("minus sign flagged as last character");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == CHAR_MINUS
                       || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)))
        else $error("character outside minus and digits");
`endif

endmodule
